FILE: hw/rtl/lebf_pkg.sv
// lebf_pkg: shared codes and types for the little-endian byte fifo
// no dependencies; imported by the lane, merge and top level modules
package lebf_pkg;

    localparam int NUM_LANES = 8;

    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_ERASE = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // command shared by all byte lanes for one access
    typedef struct packed {
        logic       we;
        logic       re;
        logic [3:0] nbytes;
    } lane_cmd_t;

    typedef logic [7:0] byte_t;

endpackage

FILE: hw/rtl/little_endian_byte_fifo.sv
// little_endian_byte_fifo: byte fifo with push, pop and peek of 1, 2, 4 or 8
// byte little-endian values, plus erase and clear.
// s_ channel carries one command beat: op, width_code, data_in, peek_offset
// and erase_count. m_ channel returns one beat per command: data_out, status
// and fill_level after the command.
// Each command passes through the accept cycle, which updates the pointers
// and issues the access to eight byte banks at once, and the FIN state,
// which picks up the registered bank read and loads the output register
// once that is free. s_ready is high only between commands, so a new
// command waits until the last one has left FIN; this is set by the
// registered read of the bank rams. m_valid rises when FIN loads the
// output register.
// The store is a ring of DEPTH rounded up to a power of two bytes, split
// into eight banks by byte address; capacity checks use DEPTH itself.
// Reset (aresetn low, synchronous) empties the fifo and drops any pending
// result; the store contents are not cleared.
// If the receiver stalls, the result waits in the output register; one more
// command may be accepted meanwhile and its result waits until it frees.
// depends on lebf_pkg, lebf_lane, lebf_merge
module little_endian_byte_fifo
    import lebf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [1:0]  s_width_code,
    input  logic [63:0] s_data_in,
    input  logic [9:0]  s_peek_offset,
    input  logic [10:0] s_erase_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_data_out,
    output logic [1:0]  m_status,
    output logic [10:0] m_fill_level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = ((LW > 11) ? LW : 11) + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FIN  = 1'b1;

    logic           state_reg, state_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [LW-1:0]  level_reg, level_next;
    logic [1:0]     stat_reg, stat_next;
    logic           rd_ok_reg, rd_ok_next;
    logic [2:0]     rot_reg, rot_next;
    logic [3:0]     n_reg, n_next;

    logic           m_valid_reg;
    logic [63:0]    m_data_reg;
    logic [1:0]     m_status_reg;
    logic [10:0]    m_fill_reg;

    logic           accept;
    logic [3:0]     nbytes;
    logic [CW-1:0]  lvl, nn, off, cnt, dep;
    logic [CW-1:0]  tail_sum, peek_sum, pop_sum, erase_sum;
    logic [CW-1:0]  push_end, peek_end, level_ext;
    lane_cmd_t      cmd;
    logic [PW-1:0]  base;
    byte_t          lane_rd [NUM_LANES];
    logic [63:0]    merged;
    logic           out_free;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign nbytes = 4'd1 << s_width_code;
    assign lvl    = CW'(level_reg);
    assign nn     = CW'(nbytes);
    assign off    = CW'(s_peek_offset);
    assign cnt    = CW'(s_erase_count);
    assign dep    = CW'(DEPTH);

    assign push_end  = lvl + nn;
    assign peek_end  = off + nn;
    assign tail_sum  = CW'(head_reg) + lvl;
    assign peek_sum  = CW'(head_reg) + off;
    assign pop_sum   = CW'(head_reg) + nn;
    assign erase_sum = CW'(head_reg) + cnt;

    always_comb begin
        head_next  = head_reg;
        level_next = level_reg;
        stat_next  = stat_reg;
        rd_ok_next = rd_ok_reg;
        rot_next   = rot_reg;
        n_next     = n_reg;
        state_next = state_reg;
        cmd        = '{we: 1'b0, re: 1'b0, nbytes: nbytes};
        base       = head_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_FIN;
                    stat_next  = ST_OK;
                    rd_ok_next = 1'b0;
                    n_next     = nbytes;
                    unique case (s_op)
                        OP_PUSH: begin
                            base = tail_sum[PW-1:0];
                            if (push_end > dep) begin
                                stat_next = ST_OVERFLOW;
                            end else begin
                                cmd.we     = 1'b1;
                                level_next = push_end[LW-1:0];
                            end
                        end
                        OP_POP: begin
                            if (lvl < nn) begin
                                stat_next = ST_SHORT;
                            end else begin
                                cmd.re     = 1'b1;
                                rd_ok_next = 1'b1;
                                head_next  = pop_sum[PW-1:0];
                                level_next = level_reg - LW'(nbytes);
                            end
                        end
                        OP_PEEK: begin
                            base = peek_sum[PW-1:0];
                            if (lvl < nn) begin
                                stat_next = ST_SHORT;
                            end else if (peek_end > lvl) begin
                                stat_next = ST_RANGE;
                            end else begin
                                cmd.re     = 1'b1;
                                rd_ok_next = 1'b1;
                            end
                        end
                        OP_ERASE: begin
                            if (cnt > lvl) begin
                                stat_next = ST_RANGE;
                            end else begin
                                head_next  = erase_sum[PW-1:0];
                                level_next = LW'(lvl - cnt);
                            end
                        end
                        OP_CLEAR: begin
                            head_next  = '0;
                            level_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    rot_next = base[2:0];
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lebf_lane #(
            .PW  (PW),
            .LANE(g)
        ) u_lane (
            .aclk   (aclk),
            .cmd    (cmd),
            .base   (base),
            .wdata  (s_data_in),
            .rd_byte(lane_rd[g])
        );
    end

    lebf_merge u_merge (
        .lane_rd (lane_rd),
        .rot     (rot_reg),
        .nbytes  (n_reg),
        .rd_ok   (rd_ok_reg),
        .data_out(merged)
    );

    assign level_ext = CW'(level_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            level_reg <= level_next;
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        stat_reg  <= stat_next;
        rd_ok_reg <= rd_ok_next;
        rot_reg   <= rot_next;
        n_reg     <= n_next;
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg   <= merged;
            m_status_reg <= stat_reg;
            m_fill_reg   <= level_ext[10:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data_out   = m_data_reg;
    assign m_status     = m_status_reg;
    assign m_fill_level = m_fill_reg;

endmodule

FILE: hw/rtl/lebf_ram.sv
// lebf_ram: generic single-port ram with registered read
// no dependencies; one instance per byte lane
module lebf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: hw/rtl/lebf_lane.sv
// lebf_lane: one byte bank of the fifo store and its address logic
// depends on lebf_pkg and lebf_ram
module lebf_lane
    import lebf_pkg::*;
#(
    parameter int PW   = 10,
    parameter int LANE = 0
) (
    input  logic            aclk,
    input  lane_cmd_t       cmd,
    input  logic [PW-1:0]   base,
    input  logic [63:0]     wdata,
    output byte_t           rd_byte
);

    logic [2:0]    j;
    logic          used;
    logic [PW-1:0] addr;
    byte_t         wbyte;

    // position of this bank's byte within the value
    assign j     = 3'(LANE) - base[2:0];
    assign used  = ({1'b0, j} < cmd.nbytes);
    assign addr  = base + PW'(j);
    assign wbyte = wdata[8*j +: 8];

    lebf_ram #(
        .WIDTH(8),
        .DEPTH(2 ** (PW - 3))
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.we & used),
        .re   (cmd.re),
        .addr (addr[PW-1:3]),
        .wdata(wbyte),
        .rdata(rd_byte)
    );

endmodule

FILE: hw/rtl/lebf_merge.sv
// lebf_merge: rotates the lane read bytes into a little-endian value
// depends on lebf_pkg
module lebf_merge
    import lebf_pkg::*;
(
    input  byte_t       lane_rd [NUM_LANES],
    input  logic [2:0]  rot,
    input  logic [3:0]  nbytes,
    input  logic        rd_ok,
    output logic [63:0] data_out
);

    always_comb begin
        logic [2:0] src;
        data_out = '0;
        for (int j = 0; j < NUM_LANES; j++) begin
            src = rot + 3'(j);
            if (rd_ok && (4'(j) < nbytes)) begin
                data_out[8*j +: 8] = lane_rd[src];
            end
        end
    end

endmodule
